/* design/hbf_pkg.sv */
// Package for the half-band FIR core: sizes, types, register indexes.
// Used by hbf_delay_line, hbf_mac_cell, halfband_fir_filter_core, hbf_output_checker and tb.
package hbf_pkg;

    localparam int NUM_SIDE_COEFS = 8;
    localparam int FRAC_BITS      = 15;
    localparam int DELAY_DEPTH    = 32;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int OUT_W      = 21;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int NUM_PAIRS  = 4;

    localparam int CENTER_TAP = 2 * NUM_SIDE_COEFS - 1;
    localparam int NUM_CELLS  = NUM_SIDE_COEFS + 1;
    localparam int DL_AW      = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int PROD_W     = SAMPLE_W + 1 + COEF_W;
    localparam int ACC_W      = PROD_W + $clog2(NUM_CELLS);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [ACC_W-1:0]    t_acc;
    typedef logic signed [OUT_W-1:0]    t_out;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;

    localparam t_cfg_idx REG_SIDE_PAIR_0 = 3'd0;
    localparam t_cfg_idx REG_SIDE_PAIR_1 = 3'd1;
    localparam t_cfg_idx REG_SIDE_PAIR_2 = 3'd2;
    localparam t_cfg_idx REG_SIDE_PAIR_3 = 3'd3;
    localparam t_cfg_idx REG_CENTER      = 3'd4;

    localparam t_coef CENTER_RESET = 16'sd16384;

    localparam t_acc OUT_MAX = t_acc'((1 <<< (OUT_W - 1)) - 1);
    localparam t_acc OUT_MIN = t_acc'(-(1 <<< (OUT_W - 1)));

endpackage

/* design/halfband_fir_filter_core.sv */
// Half-band FIR top level: config registers, delay line, MAC cell chain, output stage.
// Depends on hbf_pkg, hbf_delay_line, hbf_mac_cell.
//
//   channel  direction  handshake                 payload
//   in       sink       i_in_valid / o_in_stall   i_sample_in
//   out      source     o_out_valid / i_out_stall o_filtered
//   cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A new transaction is accepted only once the previous result has entered the output register;
// the partial sum walks the chain of NUM_SIDE_COEFS + 1 MAC cells, one per cycle.
// From input to output register a transaction passes r_start, the MAC cells and r_pend.
// Synchronous active-low reset clears the delay line and loads the reset coefficients.
// The input stalls while a transaction is in the chain or its result is waiting.
module halfband_fir_filter_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  hbf_pkg::t_sample               i_sample_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output hbf_pkg::t_out                  o_filtered,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  hbf_pkg::t_cfg_idx              i_cfg_index,
    input  logic [hbf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [hbf_pkg::CFG_DATA_W-1:0] r_side_pair [hbf_pkg::NUM_PAIRS];
    hbf_pkg::t_coef                 r_center;
    logic                           r_busy, n_busy;
    logic                           r_start;
    logic                           r_pend, n_pend;
    logic                           r_ovld, n_ovld;
    hbf_pkg::t_out                  r_out;
    logic                           w_accept;
    logic                           w_load;
    hbf_pkg::t_acc                  w_shifted;
    hbf_pkg::t_out                  w_sat;
    hbf_pkg::t_sample               w_taps [hbf_pkg::DELAY_DEPTH];
    logic                           w_vld [hbf_pkg::NUM_CELLS+1];
    hbf_pkg::t_acc                  w_acc [hbf_pkg::NUM_CELLS+1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < hbf_pkg::NUM_PAIRS; i++) begin
                r_side_pair[i] <= '0;
            end
            r_center <= hbf_pkg::CENTER_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index) inside
                hbf_pkg::REG_SIDE_PAIR_0, hbf_pkg::REG_SIDE_PAIR_1,
                hbf_pkg::REG_SIDE_PAIR_2, hbf_pkg::REG_SIDE_PAIR_3: begin
                    r_side_pair[i_cfg_index[1:0]] <= i_cfg_data;
                end
                hbf_pkg::REG_CENTER: begin
                    r_center <= i_cfg_data[hbf_pkg::COEF_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign w_accept = i_in_valid && !r_busy;
    assign o_in_stall = r_busy;

    hbf_delay_line u_delay_line (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (w_accept),
        .i_sample (i_sample_in),
        .o_taps   (w_taps)
    );

    assign w_vld[0] = r_start;
    assign w_acc[0] = '0;

    hbf_mac_cell u_center_cell (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_vld[0]),
        .i_acc   (w_acc[0]),
        .i_tap_a (w_taps[hbf_pkg::DL_AW'(hbf_pkg::CENTER_TAP % hbf_pkg::DELAY_DEPTH)]),
        .i_tap_b ('0),
        .i_coef  (r_center),
        .o_vld   (w_vld[1]),
        .o_acc   (w_acc[1])
    );

    for (genvar k = 0; k < hbf_pkg::NUM_SIDE_COEFS; k++) begin : g_side
        localparam int TAP_LO = (hbf_pkg::CENTER_TAP - 1 - 2 * k) % hbf_pkg::DELAY_DEPTH;
        localparam int TAP_HI = (hbf_pkg::CENTER_TAP + 1 + 2 * k) % hbf_pkg::DELAY_DEPTH;
        localparam int PAIR   = (k / 2) % hbf_pkg::NUM_PAIRS;
        localparam int HALF   = (k % 2) * hbf_pkg::COEF_W;

        hbf_mac_cell u_side_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[k+1]),
            .i_acc   (w_acc[k+1]),
            .i_tap_a (w_taps[hbf_pkg::DL_AW'(TAP_LO)]),
            .i_tap_b (w_taps[hbf_pkg::DL_AW'(TAP_HI)]),
            .i_coef  (r_side_pair[PAIR][HALF +: hbf_pkg::COEF_W]),
            .o_vld   (w_vld[k+2]),
            .o_acc   (w_acc[k+2])
        );
    end

    assign w_shifted = w_acc[hbf_pkg::NUM_CELLS] >>> hbf_pkg::FRAC_BITS;

    always_comb begin
        if (w_shifted > hbf_pkg::OUT_MAX) begin
            w_sat = hbf_pkg::OUT_W'(hbf_pkg::OUT_MAX);
        end else if (w_shifted < hbf_pkg::OUT_MIN) begin
            w_sat = hbf_pkg::OUT_W'(hbf_pkg::OUT_MIN);
        end else begin
            w_sat = w_shifted[hbf_pkg::OUT_W-1:0];
        end
    end

    assign w_load = r_pend && (!r_ovld || !i_out_stall);

    always_comb begin
        n_busy = r_busy;
        n_pend = r_pend;
        n_ovld = r_ovld;
        if (w_accept) begin
            n_busy = 1'b1;
        end
        if (w_vld[hbf_pkg::NUM_CELLS]) begin
            n_pend = 1'b1;
        end
        if (r_ovld && !i_out_stall) begin
            n_ovld = 1'b0;
        end
        if (w_load) begin
            n_pend = 1'b0;
            n_busy = 1'b0;
            n_ovld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_start <= 1'b0;
            r_pend  <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_start <= w_accept;
            r_pend  <= n_pend;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_sat;
        end
    end

    assign o_out_valid = r_ovld;
    assign o_filtered  = r_out;

endmodule

/* design/hbf_delay_line.sv */
// Sample delay line: a row of sample cells shifting toward the oldest tap.
// Depends on hbf_pkg.
module hbf_delay_line (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  hbf_pkg::t_sample i_sample,
    output hbf_pkg::t_sample o_taps [hbf_pkg::DELAY_DEPTH]
);

    hbf_pkg::t_sample r_tap [hbf_pkg::DELAY_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < hbf_pkg::DELAY_DEPTH; i++) begin
                r_tap[i] <= '0;
            end
        end else if (i_shift) begin
            r_tap[0] <= i_sample;
            for (int i = 1; i < hbf_pkg::DELAY_DEPTH; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
        end
    end

    assign o_taps = r_tap;

endmodule

/* design/hbf_mac_cell.sv */
// One multiply-accumulate cell: adds coef * (tap_a + tap_b) to the passing sum.
// Depends on hbf_pkg.
module hbf_mac_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  hbf_pkg::t_acc    i_acc,
    input  hbf_pkg::t_sample i_tap_a,
    input  hbf_pkg::t_sample i_tap_b,
    input  hbf_pkg::t_coef   i_coef,
    output logic             o_vld,
    output hbf_pkg::t_acc    o_acc
);

    logic signed [hbf_pkg::SAMPLE_W:0]   w_pair;
    logic signed [hbf_pkg::PROD_W-1:0]   w_prod;
    logic                                r_vld;
    hbf_pkg::t_acc                       r_acc;

    assign w_pair = (hbf_pkg::SAMPLE_W+1)'(i_tap_a) + (hbf_pkg::SAMPLE_W+1)'(i_tap_b);
    assign w_prod = hbf_pkg::PROD_W'(w_pair) * hbf_pkg::PROD_W'(i_coef);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_acc <= i_acc + hbf_pkg::ACC_W'(w_prod);
        end
    end

    assign o_vld = r_vld;
    assign o_acc = r_acc;

endmodule

/* verif/hbf_output_checker.sv */
// Output checker for the half-band FIR core: tracks coefficient writes and input
// transactions, predicts each filtered sample and compares it on the output channel.
// Depends on hbf_pkg.
module hbf_output_checker
    import hbf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_sample               i_sample_in,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out                  i_filtered,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_error_count
);
    timeunit 1ns;
    timeprecision 1ps;

    t_sample                tap_hist [DELAY_DEPTH];
    logic [CFG_DATA_W-1:0]  side_pair [NUM_PAIRS];
    t_coef                  center_gain;
    t_out                   filtered_q [$];
    int                     mismatches;

    initial begin
        o_pending     = 0;
        o_error_count = 0;
        mismatches    = 0;
    end

    // tap_hist[d] holds the sample taken d transactions ago
    function automatic t_out filter_sample();
        longint acc;
        longint pair_sum;
        longint out_hi;
        longint out_lo;
        t_coef  c;
        acc    = 0;
        out_hi = (longint'(1) <<< (OUT_W - 1)) - 1;
        out_lo = -(longint'(1) <<< (OUT_W - 1));
        for (int k = 0; k < NUM_SIDE_COEFS; k++) begin
            c = k[0] ? t_coef'(side_pair[k >> 1][31:16]) : t_coef'(side_pair[k >> 1][15:0]);
            pair_sum = longint'(tap_hist[(CENTER_TAP - 1 - 2 * k) % DELAY_DEPTH])
                     + longint'(tap_hist[(CENTER_TAP + 1 + 2 * k) % DELAY_DEPTH]);
            acc += pair_sum * longint'(c);
        end
        acc += longint'(tap_hist[CENTER_TAP % DELAY_DEPTH]) * longint'(center_gain);
        acc = acc >>> FRAC_BITS;
        if (acc > out_hi) begin
            acc = out_hi;
        end
        if (acc < out_lo) begin
            acc = out_lo;
        end
        return t_out'(acc);
    endfunction

    always @(posedge i_clk) begin : watch
        t_out want;
        if (!i_rst_n) begin
            for (int n = 0; n < DELAY_DEPTH; n++) begin
                tap_hist[n] = '0;
            end
            for (int n = 0; n < NUM_PAIRS; n++) begin
                side_pair[n] = '0;
            end
            center_gain = CENTER_RESET;
            filtered_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_SIDE_PAIR_0: side_pair[0] = i_cfg_data;
                    REG_SIDE_PAIR_1: side_pair[1] = i_cfg_data;
                    REG_SIDE_PAIR_2: side_pair[2] = i_cfg_data;
                    REG_SIDE_PAIR_3: side_pair[3] = i_cfg_data;
                    REG_CENTER:      center_gain  = t_coef'(i_cfg_data[COEF_W-1:0]);
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (filtered_q.size() == 0) begin
                    $error("filtered: unexpected transaction, actual %0d", i_filtered);
                    mismatches++;
                end else begin
                    want = filtered_q.pop_front();
                    if (i_filtered !== want) begin
                        $error("filtered: expected %0d, actual %0d", want, i_filtered);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                for (int n = DELAY_DEPTH - 1; n > 0; n--) begin
                    tap_hist[n] = tap_hist[n-1];
                end
                tap_hist[0] = i_sample_in;
                filtered_q.push_back(filter_sample());
            end
        end
        o_pending     <= filtered_q.size();
        o_error_count <= mismatches;
    end

endmodule

/* verif/tb.sv */
// Testbench top for halfband_fir_filter_core: drives samples, coefficient writes
// and output stalls; hbf_output_checker predicts and compares. Depends on hbf_pkg.
module tb;
    import hbf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = NUM_SIDE_COEFS + 8;
    localparam int PHASE_ITEMS   = 228;
    localparam int NUM_PHASES    = 8;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  in_valid   = 1'b0;
    t_sample               sample_in  = '0;
    logic                  out_stall  = 1'b0;
    logic                  cfg_valid  = 1'b0;
    t_cfg_idx              cfg_index  = REG_SIDE_PAIR_0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_stall;
    logic                  out_valid;
    t_out                  filtered;
    logic                  cfg_ready;
    int                    pending;
    int                    error_count;
    logic                  calm       = 1'b0;
    logic                  hold_high  = 1'b1;
    int                    quiet      = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    halfband_fir_filter_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_sample_in (sample_in),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_filtered  (filtered),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    hbf_output_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_sample_in   (sample_in),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_filtered    (filtered),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_pending     (pending),
        .o_error_count (error_count)
    );

    always @(posedge i_clk) begin
        out_stall <= !calm && ($urandom_range(99) < 6);
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_sample(input t_sample s);
        if (!calm && $urandom_range(99) < 6) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        sample_in <= s;
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // registers past the center index are ignored by the core
    task automatic program_coefs(input logic [CFG_DATA_W-1:0] p0, p1, p2, p3,
                                 input logic [CFG_DATA_W-1:0] ctr);
        write_reg(REG_SIDE_PAIR_0, p0);
        write_reg(REG_SIDE_PAIR_1, p1);
        write_reg(REG_SIDE_PAIR_2, p2);
        write_reg(REG_SIDE_PAIR_3, p3);
        write_reg(REG_CENTER, ctr);
        for (int u = REG_CENTER + 1; u < 2 ** CFG_IDX_W; u++) begin
            write_reg(t_cfg_idx'(u), $urandom);
        end
    endtask

    // pending is updated at the accepting edge, so wait for an edge before reading it
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mix of full-range noise, same-sign extreme runs, random-sign extremes, small values and single bits
    function automatic t_sample pick_sample();
        int      r;
        t_sample s;
        r = $urandom_range(99);
        if ($urandom_range(24) == 0) begin
            hold_high = !hold_high;
        end
        if (r < 40) begin
            s = t_sample'($urandom);
        end else if (r < 65) begin
            s = hold_high ? 16'sh7FFF : 16'sh8000;
        end else if (r < 75) begin
            s = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        end else if (r < 88) begin
            s = t_sample'($urandom_range(16)) - 16'sd8;
        end else begin
            s = t_sample'(1) << $urandom_range(SAMPLE_W - 1);
        end
        return s;
    endfunction

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset coefficients: center only
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        send_sample(16'sd0);
        send_sample(16'sd0);
        drain();

        // largest positive gains, then full-scale runs of each sign
        program_coefs(32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF);
        for (int n = 0; n < 8; n++) begin
            send_sample(16'sh7FFF);
        end
        for (int n = 0; n < 8; n++) begin
            send_sample(16'sh8000);
        end
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: program_coefs(32'h8000_8000, 32'h8000_8000, 32'h8000_8000,
                                 32'h8000_8000, 32'h8000);
                1: program_coefs('0, '0, '0, '0, '0);
                2: program_coefs(32'h8000_7FFF, 32'h7FFF_8000, 32'h8000_7FFF,
                                 32'h7FFF_8000, 32'h7FFF);
                default: program_coefs($urandom, $urandom, $urandom, $urandom, $urandom);
            endcase
            calm <= (ph == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_sample(pick_sample());
            end
            drain();
        end

        if (error_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
